/* sv/prmq_pkg.sv */
// ----------------------------------------------------------------------------
// prmq_pkg
// Shared constants, entry layout and ring pointer helpers for the priority
// message ring queue.
// ----------------------------------------------------------------------------
package prmq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic CMD_POST = 1'b0;
	localparam logic CMD_PEND = 1'b1;

	typedef struct packed {
		logic [7:0]  etype;
		logic [7:0]  prio;
		logic [31:0] value;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == '0) begin
			r = PTR_W'(QUEUE_DEPTH - 1);
		end else begin
			r = p - PTR_W'(1);
		end
		return r;
	endfunction

endpackage

/* sv/prmq_ram.sv */
// ----------------------------------------------------------------------------
// prmq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module prmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/priority_message_ring_queue_unit.sv */
// ----------------------------------------------------------------------------
// priority_message_ring_queue_unit
// Bounded message queue in a ring RAM with optional priority-sorted insertion.
// ----------------------------------------------------------------------------
// One word is taken at a time. A pend reads the head entry and registers it
// as the result; a refused post and a post in FIFO mode or into an empty
// queue go straight to the result; a sorted post walks back from the tail
// one step per stored entry the new message passes, each step one read and
// one write of the single entry RAM. One result waiting on a stalled output
// does not block the next word; the result of that next word then holds the
// block until the output register frees. The user must write priority_mode
// only while the block is idle; not enforced. It only affects later posts.
module priority_message_ring_queue_unit
	import prmq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [7:0]  in_type,
	input  logic [7:0]  in_priority,
	input  logic [31:0] in_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [7:0]  out_type,
	output logic [7:0]  out_priority,
	output logic [31:0] out_value
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WALK  = 3'd1;
	localparam logic [2:0] ST_PLACE = 3'd2;
	localparam logic [2:0] ST_PEND  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d, pos_q, pos_d;
	logic [CNT_W-1:0] count_q, count_d, k_q, k_d;
	logic             mode_q;
	entry_t           new_q, new_d, res_q, res_d;
	logic             res_ok_q, res_ok_d;
	logic             out_valid_q;
	logic             out_ok_q;
	entry_t           out_q;

	logic             ram_we;
	logic [PTR_W-1:0] ram_waddr, ram_raddr;
	entry_t           ram_wdata, ram_rdata;

	entry_t           in_entry;
	logic             accept, load_out;

	assign in_entry = '{etype: in_type, prio: in_priority, value: in_value};
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	prmq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		pos_d     = pos_q;
		k_d       = k_q;
		new_d     = new_q;
		res_d     = res_q;
		res_ok_d  = res_ok_q;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = new_q;
		ram_raddr = head_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_d   = '0;
					state_d = ST_DONE;
					if (cmd == CMD_POST) begin
						if (count_q == CNT_W'(QUEUE_DEPTH)) begin
							res_ok_d = 1'b0;
						end else begin
							res_ok_d = 1'b1;
							tail_d   = ptr_inc(tail_q);
							count_d  = count_q + CNT_W'(1);
							if (mode_q && (count_q != '0)) begin
								// start the walk: look at the entry ahead of the tail
								ram_raddr = ptr_dec(tail_q);
								pos_d     = tail_q;
								k_d       = count_q;
								new_d     = in_entry;
								state_d   = ST_WALK;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = tail_q;
								ram_wdata = in_entry;
							end
						end
					end else begin
						if (count_q == '0) begin
							res_ok_d = 1'b0;
						end else begin
							ram_raddr = head_q;
							state_d   = ST_PEND;
						end
					end
				end
			end
			ST_WALK: begin
				ram_we = 1'b1;
				if (new_q.prio > ram_rdata.prio) begin
					// shift the older entry one place back
					ram_wdata = ram_rdata;
					pos_d     = ptr_dec(pos_q);
					k_d       = k_q - CNT_W'(1);
					if (k_q == CNT_W'(1)) begin
						state_d = ST_PLACE;
					end else begin
						ram_raddr = ptr_dec(ptr_dec(pos_q));
					end
				end else begin
					ram_wdata = new_q;
					state_d   = ST_DONE;
				end
			end
			ST_PLACE: begin
				ram_we    = 1'b1;
				ram_wdata = new_q;
				state_d   = ST_DONE;
			end
			ST_PEND: begin
				res_ok_d = 1'b1;
				res_d    = ram_rdata;
				head_d   = ptr_inc(head_q);
				count_d  = count_q - CNT_W'(1);
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			mode_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q    <= pos_d;
		k_q      <= k_d;
		new_q    <= new_d;
		res_q    <= res_d;
		res_ok_q <= res_ok_d;
		if (load_out) begin
			out_ok_q <= res_ok_q;
			out_q    <= res_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign ok           = out_ok_q;
	assign out_type     = out_q.etype;
	assign out_priority = out_q.prio;
	assign out_value    = out_q.value;

endmodule

/* sv/prmq_checker.sv */
// ----------------------------------------------------------------------------
// prmq_checker
// Port-level checks for the priority message ring queue, bound to the top.
// ----------------------------------------------------------------------------
module prmq_checker
	import prmq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic        cfg_wdata,
	input logic        in_valid,
	input logic        in_stall,
	input logic        cmd,
	input logic [7:0]  in_type,
	input logic [7:0]  in_priority,
	input logic [31:0] in_value,
	input logic        out_valid,
	input logic        out_stall,
	input logic        ok,
	input logic [7:0]  out_type,
	input logic [7:0]  out_priority,
	input logic [31:0] out_value
);

	// a waiting result word stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// one word in flight: input closes right after an acceptance
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word accepted while busy");

	// refused results carry no message
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> out_type == 8'd0 && out_priority == 8'd0 && out_value == 32'd0)
		else $error("refused result carries a message");

	// a result cannot appear in the cycle right after its word was taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind priority_message_ring_queue_unit prmq_checker u_prmq_checker (.*);
